/* rtl/srlat_pkg.sv */
// shared types, constants and constant functions for the sensor ring line angle tracker
// no dependencies; used by every module of the block
package srlat_pkg;

   // ring geometry and lane split
   localparam int SENSOR_COUNT = 24;
   localparam int LANES        = 8;
   localparam int EPL          = (SENSOR_COUNT + LANES - 1) / LANES;
   localparam int EPL_IDX_W    = (EPL > 1) ? $clog2(EPL) : 1;

   // fixed point
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int DEG_ONE      = 65536;
   localparam int CORDIC_UNIT  = 9949;
   localparam int TERM_W       = 16;
   localparam int SUM_W        = 21;
   localparam int XY_W         = 23;
   localparam int Z_W          = 26;
   localparam int D_W          = 27;
   localparam int ANGLE_W      = 9;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATCHED_MASK = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_DEG    = 1'b1;
   localparam logic [7:0] RANGE_DEG_RESET = 8'd45;

   // atan(2^-k) in q.16 degrees
   localparam int ATAN_Q16 [CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   typedef logic signed [TERM_W-1:0] term_type;

   typedef enum logic [1:0] {
      ZONE_CLEAR    = 2'd0,
      ZONE_TOUCHING = 2'd1,
      ZONE_CROSSED  = 2'd2
   } zone_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_MERGE,
      ST_CORDIC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } lane_ctrl_type;

   typedef struct packed {
      logic               vector_seen;
      logic [ANGLE_W-1:0] vector_angle;
      logic               line_seen;
      logic [ANGLE_W-1:0] line_angle;
      zone_type           zone;
   } result_type;

   // sine or cosine of one sensor's direction, q1.14, worked out at elaboration
   function automatic term_type sensor_term(int idx, bit want_sin);
      int th;
      int deg;
      int x;
      int y;
      int z;
      int nx;
      int ny;
      bit neg;
      th = (450 - idx * (360 / SENSOR_COUNT)) % 360;
      if (th < 0) th = th + 360;
      deg = th;
      neg = 1'b0;
      if (deg > 180) deg = deg - 360;
      if (deg > 90) begin
         deg = deg - 180;
         neg = 1'b1;
      end else if (deg < -90) begin
         deg = deg + 180;
         neg = 1'b1;
      end
      x = CORDIC_UNIT;
      y = 0;
      z = deg * DEG_ONE;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (z >= 0) begin
            nx = x - (y >>> k);
            ny = y + (x >>> k);
            z  = z - ATAN_Q16[k];
         end else begin
            nx = x + (y >>> k);
            ny = y - (x >>> k);
            z  = z + ATAN_Q16[k];
         end
         x = nx;
         y = ny;
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      return want_sin ? TERM_W'(y) : TERM_W'(x);
   endfunction

endpackage

/* rtl/srlat_lane.sv */
// one accumulation lane: sums the unit vectors of its lit sensors, one sensor a cycle
// depends on srlat_pkg
module srlat_lane (
   input  logic                                 clock,
   input  srlat_pkg::lane_ctrl_type             ctrl,
   input  logic [srlat_pkg::EPL_IDX_W-1:0]      idx,
   input  logic [srlat_pkg::EPL-1:0]            lit,
   input  srlat_pkg::term_type                  sin_term [srlat_pkg::EPL],
   input  srlat_pkg::term_type                  cos_term [srlat_pkg::EPL],
   output logic signed [srlat_pkg::SUM_W-1:0]   sum_x,
   output logic signed [srlat_pkg::SUM_W-1:0]   sum_y
);

   logic signed [srlat_pkg::SUM_W-1:0] acc_x_ff, acc_x_in;
   logic signed [srlat_pkg::SUM_W-1:0] acc_y_ff, acc_y_in;

   // add the selected sensor's vector when it is lit
   always_comb begin
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      if (ctrl.clear) begin
         acc_x_in = '0;
         acc_y_in = '0;
      end else if (ctrl.step && lit[idx]) begin
         acc_x_in = acc_x_ff + srlat_pkg::SUM_W'(sin_term[idx]);
         acc_y_in = acc_y_ff + srlat_pkg::SUM_W'(cos_term[idx]);
      end
   end

   always_ff @(posedge clock) begin
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
   end

   assign sum_x = acc_x_ff;
   assign sum_y = acc_y_ff;

endmodule

/* rtl/srlat_atan.sv */
// iterative vectoring cordic: atan2 of the merged sums in q.16 degrees, one step a cycle
// depends on srlat_pkg
module srlat_atan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic signed [srlat_pkg::SUM_W-1:0]  sum_x,
   input  logic signed [srlat_pkg::SUM_W-1:0]  sum_y,
   output logic signed [srlat_pkg::Z_W-1:0]    angle,
   output logic                                done
);

   localparam logic signed [srlat_pkg::Z_W-1:0] HALF_TURN =
      srlat_pkg::Z_W'(180 * srlat_pkg::DEG_ONE);

   logic signed [srlat_pkg::XY_W-1:0]  x_ff, x_in;
   logic signed [srlat_pkg::XY_W-1:0]  y_ff, y_in;
   logic signed [srlat_pkg::Z_W-1:0]   z_ff, z_in;
   logic [srlat_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                               busy_ff, busy_in;
   logic signed [srlat_pkg::XY_W-1:0]  load_x, load_y;
   logic signed [srlat_pkg::XY_W-1:0]  sh_x, sh_y;
   logic signed [srlat_pkg::Z_W-1:0]   atan_k;

   assign load_x = srlat_pkg::XY_W'(sum_x);
   assign load_y = srlat_pkg::XY_W'(sum_y);
   assign sh_x   = x_ff >>> step_ff;
   assign sh_y   = y_ff >>> step_ff;
   assign atan_k = srlat_pkg::Z_W'(srlat_pkg::ATAN_Q16[step_ff]);
   assign done   = busy_ff && (step_ff == srlat_pkg::STEP_W'(srlat_pkg::CORDIC_STEPS - 1));

   // fold into the right half plane on load, then rotate toward the x axis
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (load) begin
         step_in = '0;
         busy_in = 1'b1;
         if (load_x < 0) begin
            x_in = -load_x;
            y_in = -load_y;
            z_in = (load_y >= 0) ? HALF_TURN : -HALF_TURN;
         end else begin
            x_in = load_x;
            y_in = load_y;
            z_in = '0;
         end
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (done) busy_in = 1'b0;
         // a vector already on the axis stays put
         if (y_ff > 0) begin
            x_in = x_ff + sh_y;
            y_in = y_ff - sh_x;
            z_in = z_ff + atan_k;
         end else if (y_ff < 0) begin
            x_in = x_ff - sh_y;
            y_in = y_ff + sh_x;
            z_in = z_ff - atan_k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign angle = z_ff;

endmodule

/* rtl/srlat_zone.sv */
// angle cut to whole degrees and the clear / touching / crossed zone tracker
// depends on srlat_pkg
module srlat_zone (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               update,
   input  logic                               any,
   input  logic signed [srlat_pkg::Z_W-1:0]   angle,
   input  logic [7:0]                         range_deg,
   output srlat_pkg::result_type              result
);

   localparam logic signed [srlat_pkg::D_W-1:0] HALF_TURN =
      srlat_pkg::D_W'(180 * srlat_pkg::DEG_ONE);

   srlat_pkg::zone_type          zone_ff, zone_in;
   logic [srlat_pkg::ANGLE_W-1:0] first_ff, first_in;
   logic [srlat_pkg::ANGLE_W-1:0] prev_ff, prev_in;
   logic [srlat_pkg::ANGLE_W-1:0] held_ff, held_in;
   logic                          first_ok_ff, first_ok_in;
   logic                          prev_ok_ff, prev_ok_in;
   logic                          held_ok_ff, held_ok_in;

   logic signed [srlat_pkg::D_W-1:0] d;
   logic [srlat_pkg::D_W-1:0]        d_mag;
   logic signed [11:0]               deg_raw;
   logic signed [11:0]               deg_wrap;
   logic [srlat_pkg::ANGLE_W-1:0]    v;
   logic                             match_prev;
   logic                             match_first;

   // two angles match when they differ by at most range_deg around the circle
   function automatic logic angle_match(logic [8:0] a, logic [8:0] b, logic b_ok,
                                        logic [7:0] r);
      logic signed [10:0] t;
      logic signed [10:0] r_s;
      t   = $signed({2'b00, b}) - $signed({2'b00, a});
      r_s = $signed({3'b000, r});
      if (t < 0) t = t + 11'sd360;
      return b_ok && ((t <= r_s) || (t >= 11'sd360 - r_s));
   endfunction

   // 180 minus atan2, cut toward zero, wrapped into 0..359
   always_comb begin
      d       = HALF_TURN - srlat_pkg::D_W'(angle);
      d_mag   = (d < 0) ? srlat_pkg::D_W'(-d) : srlat_pkg::D_W'(d);
      deg_raw = (d < 0) ? -$signed({1'b0, d_mag[26:16]}) : $signed({1'b0, d_mag[26:16]});
      deg_wrap = deg_raw;
      if (deg_wrap < 0) deg_wrap = deg_wrap + 12'sd360;
      if (deg_wrap >= 12'sd360) deg_wrap = deg_wrap - 12'sd360;
      v = deg_wrap[srlat_pkg::ANGLE_W-1:0];
   end

   assign match_prev  = angle_match(v, prev_ff, prev_ok_ff, range_deg);
   assign match_first = angle_match(v, first_ff, first_ok_ff, range_deg);

   // next zone
   always_comb begin
      zone_in = zone_ff;
      if (any) begin
         case (zone_ff)
            srlat_pkg::ZONE_CLEAR:    zone_in = srlat_pkg::ZONE_TOUCHING;
            srlat_pkg::ZONE_TOUCHING: if (!match_prev) zone_in = srlat_pkg::ZONE_CROSSED;
            srlat_pkg::ZONE_CROSSED:  if (match_first) zone_in = srlat_pkg::ZONE_TOUCHING;
            default:                  zone_in = zone_ff;
         endcase
      end else if (zone_ff != srlat_pkg::ZONE_CROSSED) begin
         zone_in = srlat_pkg::ZONE_CLEAR;
      end
   end

   // held angles
   always_comb begin
      first_in    = first_ff;
      first_ok_in = first_ok_ff;
      held_in     = held_ff;
      held_ok_in  = held_ok_ff;
      prev_in     = v;
      prev_ok_in  = any;
      if (any) begin
         case (zone_ff)
            srlat_pkg::ZONE_CLEAR: begin
               first_in    = v;
               first_ok_in = 1'b1;
               held_in     = v;
               held_ok_in  = 1'b1;
            end
            srlat_pkg::ZONE_TOUCHING: begin
               if (match_prev) begin
                  first_in    = v;
                  first_ok_in = 1'b1;
                  held_in     = v;
                  held_ok_in  = 1'b1;
               end
            end
            srlat_pkg::ZONE_CROSSED: begin
               held_in    = first_ff;
               held_ok_in = first_ok_ff;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end else if (zone_ff == srlat_pkg::ZONE_CROSSED) begin
         held_in    = first_ff;
         held_ok_in = first_ok_ff;
      end else begin
         first_ok_in = 1'b0;
         held_ok_in  = 1'b0;
      end
   end

   // result item fields
   always_comb begin
      result.vector_seen  = any;
      result.vector_angle = any ? v : '0;
      result.line_seen    = held_ok_in;
      result.line_angle   = held_ok_in ? held_in : '0;
      result.zone         = zone_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff     <= srlat_pkg::ZONE_CLEAR;
         first_ok_ff <= 1'b0;
         prev_ok_ff  <= 1'b0;
         held_ok_ff  <= 1'b0;
      end else if (update) begin
         zone_ff     <= zone_in;
         first_ok_ff <= first_ok_in;
         prev_ok_ff  <= prev_ok_in;
         held_ok_ff  <= held_ok_in;
      end
      if (update) begin
         first_ff <= first_in;
         prev_ff  <= prev_in;
         held_ff  <= held_in;
      end
   end

endmodule

/* rtl/sensor_ring_line_angle_tracker.sv */
// top level: patching, lane sequencer, merge, cordic, zone tracker and result register
// depends on srlat_pkg, srlat_lane, srlat_atan, srlat_zone
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_white_mask
//  rsp     | out       | rsp_valid/rsp_stall | vector_seen/angle, line_seen/angle, zone
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one item at a time: an accepted item walks the lanes, is merged, runs the 16-step
// vectoring cordic and passes the finish state; the eight lanes walk their sensors
// one per cycle ahead of the cordic. reset is synchronous; it clears the zone, the
// held angle valid bits, the sequencer, the patched mask and rsp_valid and sets
// range_deg to 45. a finished result waits in the output register; a stalled rsp
// only holds the block once the next result is ready. csr writes are always taken.
module sensor_ring_line_angle_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [srlat_pkg::SENSOR_COUNT-1:0]     req_white_mask,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_vector_seen,
   output logic [srlat_pkg::ANGLE_W-1:0]          rsp_vector_angle,
   output logic                                   rsp_line_seen,
   output logic [srlat_pkg::ANGLE_W-1:0]          rsp_line_angle,
   output logic [1:0]                             rsp_zone,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [srlat_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [srlat_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int N = srlat_pkg::SENSOR_COUNT;
   localparam logic [srlat_pkg::EPL_IDX_W-1:0] LAST_IDX =
      srlat_pkg::EPL_IDX_W'(srlat_pkg::EPL - 1);

   srlat_pkg::state_type                  state_ff, state_in;
   logic [N-1:0]                          patched_mask_ff, patched_mask_in;
   logic [7:0]                            range_deg_ff, range_deg_in;
   logic [N-1:0]                          lit_ff, lit_in;
   logic                                  any_ff, any_in;
   logic [srlat_pkg::EPL_IDX_W-1:0]       idx_ff, idx_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   srlat_pkg::result_type                 rsp_result_ff, rsp_result_in;

   logic                                  accept;
   logic                                  slot_free;
   logic                                  atan_load;
   logic                                  atan_done;
   logic                                  zone_update;
   srlat_pkg::lane_ctrl_type              lane_ctrl;
   logic [N-1:0]                          patched;
   logic signed [srlat_pkg::SUM_W-1:0]    lane_x [srlat_pkg::LANES];
   logic signed [srlat_pkg::SUM_W-1:0]    lane_y [srlat_pkg::LANES];
   logic signed [srlat_pkg::SUM_W-1:0]    merge_x, merge_y;
   logic signed [srlat_pkg::Z_W-1:0]      atan_angle;
   srlat_pkg::result_type                 zone_result;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      patched_mask_in = patched_mask_ff;
      range_deg_in    = range_deg_ff;
      if (csr_valid) begin
         case (csr_index)
            srlat_pkg::CSR_PATCHED_MASK: patched_mask_in = N'(csr_data);
            srlat_pkg::CSR_RANGE_DEG:    range_deg_in    = csr_data[7:0];
            default:                     range_deg_in    = range_deg_ff;
         endcase
      end
   end

   // patched sensors take the or of their two raw neighbors
   for (genvar i = 0; i < N; i++) begin : g_patch
      localparam int LO = (i + N - 1) % N;
      localparam int HI = (i + 1) % N;
      assign patched[i] = patched_mask_ff[i] ? (req_white_mask[LO] | req_white_mask[HI])
                                             : req_white_mask[i];
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srlat_pkg::ST_IDLE:   if (accept) state_in = srlat_pkg::ST_ACC;
         srlat_pkg::ST_ACC:    if (idx_ff == LAST_IDX) state_in = srlat_pkg::ST_MERGE;
         srlat_pkg::ST_MERGE:  state_in = srlat_pkg::ST_CORDIC;
         srlat_pkg::ST_CORDIC: if (atan_done) state_in = srlat_pkg::ST_FINISH;
         srlat_pkg::ST_FINISH: if (slot_free) state_in = srlat_pkg::ST_IDLE;
         default:              state_in = srlat_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall       = 1'b1;
      lane_ctrl.clear = 1'b0;
      lane_ctrl.step  = 1'b0;
      atan_load       = 1'b0;
      zone_update     = 1'b0;
      case (state_ff)
         srlat_pkg::ST_IDLE: begin
            req_stall       = 1'b0;
            lane_ctrl.clear = 1'b1;
         end
         srlat_pkg::ST_ACC:    lane_ctrl.step = 1'b1;
         srlat_pkg::ST_MERGE:  atan_load = 1'b1;
         srlat_pkg::ST_CORDIC: atan_load = 1'b0;
         srlat_pkg::ST_FINISH: zone_update = slot_free;
         default:              req_stall = 1'b1;
      endcase
   end

   // item capture, lane index and result register
   always_comb begin
      lit_in        = lit_ff;
      any_in        = any_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      if (accept) begin
         lit_in = patched;
         any_in = |patched;
         idx_in = '0;
      end else if (lane_ctrl.step) begin
         idx_in = idx_ff + 1'b1;
      end
      if (zone_update) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = zone_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= srlat_pkg::ST_IDLE;
         patched_mask_ff <= '0;
         range_deg_ff    <= srlat_pkg::RANGE_DEG_RESET;
         rsp_valid_ff    <= 1'b0;
         idx_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         patched_mask_ff <= patched_mask_in;
         range_deg_ff    <= range_deg_in;
         rsp_valid_ff    <= rsp_valid_in;
         idx_ff          <= idx_in;
      end
      lit_ff        <= lit_in;
      any_ff        <= any_in;
      rsp_result_ff <= rsp_result_in;
   end

   // lanes, each with its own constant slice of the vector table
   for (genvar l = 0; l < srlat_pkg::LANES; l++) begin : g_lane
      srlat_pkg::term_type           sin_term [srlat_pkg::EPL];
      srlat_pkg::term_type           cos_term [srlat_pkg::EPL];
      logic [srlat_pkg::EPL-1:0]     lane_lit;

      for (genvar j = 0; j < srlat_pkg::EPL; j++) begin : g_elem
         localparam int IDX = l * srlat_pkg::EPL + j;
         if (IDX < N) begin : g_on
            assign sin_term[j] = srlat_pkg::sensor_term(IDX, 1'b1);
            assign cos_term[j] = srlat_pkg::sensor_term(IDX, 1'b0);
            assign lane_lit[j] = lit_ff[IDX];
         end else begin : g_off
            assign sin_term[j] = '0;
            assign cos_term[j] = '0;
            assign lane_lit[j] = 1'b0;
         end
      end

      srlat_lane u_lane (
         .clock    (clock),
         .ctrl     (lane_ctrl),
         .idx      (idx_ff),
         .lit      (lane_lit),
         .sin_term (sin_term),
         .cos_term (cos_term),
         .sum_x    (lane_x[l]),
         .sum_y    (lane_y[l])
      );
   end

   // merge what the lanes found
   always_comb begin
      merge_x = '0;
      merge_y = '0;
      for (int l = 0; l < srlat_pkg::LANES; l++) begin
         merge_x = merge_x + lane_x[l];
         merge_y = merge_y + lane_y[l];
      end
   end

   srlat_atan u_atan (
      .clock (clock),
      .reset (reset),
      .load  (atan_load),
      .sum_x (merge_x),
      .sum_y (merge_y),
      .angle (atan_angle),
      .done  (atan_done)
   );

   srlat_zone u_zone (
      .clock     (clock),
      .reset     (reset),
      .update    (zone_update),
      .any       (any_ff),
      .angle     (atan_angle),
      .range_deg (range_deg_ff),
      .result    (zone_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vector_seen  = rsp_result_ff.vector_seen;
   assign rsp_vector_angle = rsp_result_ff.vector_angle;
   assign rsp_line_seen    = rsp_result_ff.line_seen;
   assign rsp_line_angle   = rsp_result_ff.line_angle;
   assign rsp_zone         = rsp_result_ff.zone;

endmodule

/* rtl/srlat_checker.sv */
// port-level checks for the sensor ring line angle tracker, bound to the top level
// depends on srlat_pkg and sensor_ring_line_angle_tracker
module srlat_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_vector_seen,
   input logic [srlat_pkg::ANGLE_W-1:0]       rsp_vector_angle,
   input logic                                rsp_line_seen,
   input logic [srlat_pkg::ANGLE_W-1:0]       rsp_line_angle,
   input logic [1:0]                          rsp_zone
);

   // a stalled result item stays valid and keeps its angles and zone
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_vector_angle)
         && $stable(rsp_line_angle) && $stable(rsp_zone))
      else $error("stalled result item changed");

   // one item at a time: the input is closed right after an accept
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input item accepted while busy");

   // angles stay on the circle and read zero when absent
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_vector_angle < 9'd360 && rsp_line_angle < 9'd360
         && (rsp_vector_seen || rsp_vector_angle == '0)
         && (rsp_line_seen || rsp_line_angle == '0))
      else $error("result angle out of range");

   // clear zone means nothing seen and no line held
   a_clear_zone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zone == srlat_pkg::ZONE_CLEAR |-> !rsp_vector_seen && !rsp_line_seen)
      else $error("clear zone with a line held");

endmodule

bind sensor_ring_line_angle_tracker srlat_checker u_checker (.*);
